// ===== rtl/integer_to_radix_digits_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Shared concurrent-check wrappers. Each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itrd_pkg.sv =====
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared constants and controller/datapath interface types for the radix
// digit converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

	// Fixed field widths.
	localparam int VALUE_W = 64;
	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 16;
	localparam int DIGIT_W = 6;

	// Default operand width and dividend bits retired per divider cycle.
	localparam int VALUE_BITS_DEF = 64;
	localparam int STEP_BITS      = 8;

	// Radix limits and digit code units.
	localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
	localparam logic [BASE_W-1:0] RADIX_TEN = 6'd10;
	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 16'd48;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 16'd97;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new input word
		logic step;      // retire one dividend chunk in the divider
		logic store;     // write the finished remainder to the digit store
		logic rd;        // read the next digit, most significant first
		logic ld_digit;  // load a digit word into the output register
		logic ld_spec;   // load the empty-result word into the output register
	} itrd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_base;
		logic val_zero;
		logic cnt_zero;
		logic first_chunk;
		logic last_chunk;
		logic out_free;
	} itrd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_digits_top.sv =====
// ---------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts an integer to its digit code units in a radix from 2 to 36,
// most significant digit first, one output word per digit.
// ---------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  -------  -------------------  --------------------------------------
//  input    in_valid / in_ready  value, is_signed, base
//  output   out_valid/out_ready  char_out, no_digits, bad_base, last
//  config   cfg_we               cfg_wdata (zero digit code unit)
//
// Each digit takes CHUNKS = ceil(VALUE_BITS/8) steps of the shared divider,
// which retires 8 dividend bits per cycle; digits are then emitted from the
// registered digit store read port.
// Reset is asynchronous, active low, and needs no clearing pass.
// A stalled output holds the converter; a new input word is taken while the
// final output word still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits_top #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [itrd_pkg::CHAR_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [itrd_pkg::VALUE_W-1:0]  value,
	input  wire logic                          is_signed,
	input  wire logic [itrd_pkg::BASE_W-1:0]   base,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]        char_out,
	output logic                               no_digits,
	output logic                               bad_base,
	output logic                               last
);
	import itrd_pkg::*;

	itrd_cmd_t cmd;
	itrd_sts_t sts;

	// Sequencer.
	itrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Divider, digit store and output register.
	itrd_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (value),
		.is_signed (is_signed),
		.base      (base),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.no_digits (no_digits),
		.bad_base  (bad_base),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== rtl/itrd_ctrl.sv =====
// ---------------------------------------------------------------------------
// itrd_ctrl
// Sequencer for the radix digit converter: accept, divide, emit.
// ---------------------------------------------------------------------------
`default_nettype none

module itrd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire itrd_pkg::itrd_sts_t sts,
	output itrd_pkg::itrd_cmd_t   cmd
);
	import itrd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SPEC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				// At a digit boundary, decide whether division is finished.
				if (sts.first_chunk && sts.bad_base) begin
					state_d = ST_SPEC;
				end else if (sts.first_chunk && sts.val_zero) begin
					if (sts.cnt_zero) begin
						state_d = ST_SPEC;
					end else begin
						cmd.rd  = 1'b1;
						state_d = ST_EMIT;
					end
				end else begin
					cmd.step  = 1'b1;
					cmd.store = sts.last_chunk;
				end
			end
			ST_SPEC: begin
				if (sts.out_free) begin
					cmd.ld_spec = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EMIT: begin
				// Hand over one digit and fetch the next one in the same cycle.
				if (sts.out_free) begin
					cmd.ld_digit = 1'b1;
					if (sts.cnt_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/itrd_dpath.sv =====
// ---------------------------------------------------------------------------
// itrd_dpath
// Datapath: operand magnitude, chunked radix divider, digit store, code unit
// mapping and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_radix_digits_top_macros.svh"

module itrd_dpath #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [itrd_pkg::CHAR_W-1:0]   cfg_wdata,
	input  wire logic [itrd_pkg::VALUE_W-1:0]  value,
	input  wire logic                          is_signed,
	input  wire logic [itrd_pkg::BASE_W-1:0]   base,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]        char_out,
	output logic                               no_digits,
	output logic                               bad_base,
	output logic                               last,
	input  wire itrd_pkg::itrd_cmd_t           cmd,
	output itrd_pkg::itrd_sts_t                sts
);
	import itrd_pkg::*;

	localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PADW   = CHUNKS * STEP_BITS;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int AW     = $clog2(VALUE_BITS);
	localparam int NW     = $clog2(VALUE_BITS + 1);

	// One divider chunk: STEP_BITS restoring steps with a narrow remainder.
	function automatic logic [STEP_BITS+DIGIT_W-1:0] div_chunk(
		input logic [DIGIT_W-1:0]   rem_in,
		input logic [STEP_BITS-1:0] bits_in,
		input logic [BASE_W-1:0]    divisor
	);
		logic [DIGIT_W:0]     t;
		logic [DIGIT_W-1:0]   r;
		logic [STEP_BITS-1:0] q;
		r = rem_in;
		q = '0;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			t = {r, bits_in[i]};
			if (t >= {1'b0, divisor}) begin
				t    = t - {1'b0, divisor};
				q[i] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		return {q, r};
	endfunction

	logic [CHAR_W-1:0]    zero_digit_q;
	logic [PADW-1:0]      val_q;
	logic [BASE_W-1:0]    base_q;
	logic                 bad_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [CW-1:0]        chunk_q;
	logic [NW-1:0]        cnt_q;
	logic [DIGIT_W-1:0]   digit_mem [VALUE_BITS];
	logic [DIGIT_W-1:0]   rd_data_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 nd_q;
	logic                 bb_q;
	logic                 last_q;

	logic [VALUE_BITS-1:0]        mag;
	logic [STEP_BITS+DIGIT_W-1:0] step_res;
	logic [STEP_BITS-1:0]         q_bits;
	logic [DIGIT_W-1:0]           r_next;
	logic [AW-1:0]                rd_addr;
	logic                         out_free;
	logic                         locale_mode;
	logic [CHAR_W-1:0]            digit_char;

	// Operand magnitude from the low VALUE_BITS bits.
	always_comb begin
		mag = value[VALUE_BITS-1:0];
		if (is_signed && mag[VALUE_BITS-1]) begin
			mag = ~mag + VALUE_BITS'(1);
		end
	end

	// Divider cycle on the top chunk of the working word.
	assign step_res = div_chunk(rem_q, val_q[PADW-1 -: STEP_BITS], base_q);
	assign q_bits   = step_res[STEP_BITS+DIGIT_W-1:DIGIT_W];
	assign r_next   = step_res[DIGIT_W-1:0];
	assign rd_addr  = AW'(cnt_q - NW'(1));
	assign out_free = !out_valid_q || out_ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_digit_q <= ASCII_ZERO;
		end else if (cfg_we) begin
			zero_digit_q <= cfg_wdata;
		end
	end

	// Divider control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.load) begin
			chunk_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.step) begin
			if (cmd.store) begin
				chunk_q <= '0;
				cnt_q   <= cnt_q + NW'(1);
			end else begin
				chunk_q <= chunk_q + CW'(1);
			end
		end else if (cmd.rd) begin
			cnt_q <= cnt_q - NW'(1);
		end
	end

	// Working word, radix and partial remainder.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= PADW'(mag);
			base_q <= base;
			bad_q  <= (base < BASE_MIN) || (base > BASE_MAX);
			rem_q  <= '0;
		end else if (cmd.step) begin
			val_q <= (val_q << STEP_BITS) | PADW'(q_bits);
			rem_q <= cmd.store ? '0 : r_next;
		end
	end

	// Digit store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			digit_mem[cnt_q[AW-1:0]] <= r_next;
		end
		if (cmd.rd) begin
			rd_data_q <= digit_mem[rd_addr];
		end
	end

	// Digit to code unit.
	assign locale_mode = (base_q == RADIX_TEN) && (zero_digit_q != ASCII_ZERO);
	always_comb begin
		if (locale_mode) begin
			digit_char = zero_digit_q + CHAR_W'(rd_data_q);
		end else if (rd_data_q < DIGIT_W'(RADIX_TEN)) begin
			digit_char = ASCII_ZERO + CHAR_W'(rd_data_q);
		end else begin
			digit_char = ASCII_LOWER_A - CHAR_W'(RADIX_TEN) + CHAR_W'(rd_data_q);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_digit || cmd.ld_spec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.ld_digit) begin
			char_q <= digit_char;
			nd_q   <= 1'b0;
			bb_q   <= 1'b0;
			last_q <= (cnt_q == '0);
		end else if (cmd.ld_spec) begin
			char_q <= '0;
			nd_q   <= 1'b1;
			bb_q   <= bad_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign no_digits = nd_q;
	assign bad_base  = bb_q;
	assign last      = last_q;

	// Status back to the controller.
	always_comb begin
		sts             = '0;
		sts.bad_base    = bad_q;
		sts.val_zero    = (val_q == '0);
		sts.cnt_zero    = (cnt_q == '0);
		sts.first_chunk = (chunk_q == '0);
		sts.last_chunk  = (chunk_q == CW'(CHUNKS - 1));
		sts.out_free    = out_free;
	end

	// A word is only loaded when the output register is free or being emptied.
	`ITRD_ASSERT_IMP(a_load_free, cmd.ld_digit || cmd.ld_spec, out_free, "output word overwritten")
	// The digit store never overflows.
	`ITRD_ASSERT_IMP(a_store_room, cmd.store, cnt_q < NW'(VALUE_BITS), "digit store overflow")
	// A read is issued only while digits remain, and leaves one fewer.
	`ITRD_ASSERT_NXT(a_rd_count, cmd.rd && (cnt_q != '0), cnt_q == $past(cnt_q) - NW'(1), "digit count slip")

endmodule

`default_nettype wire
